// ----- rtl/ppsm_pkg.sv -----
package ppsm_pkg;

   localparam int LIMIT_BITS = 20;
   localparam int CUR_BITS   = LIMIT_BITS + 1;
   localparam int PROD_BITS  = 2 * LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = {LIMIT_BITS{1'b1}};
   localparam logic [CUR_BITS-1:0]   CURSOR_START = CUR_BITS'(2);

   localparam logic signed [1:0] CHAR_ZERO = 2'sb00;
   localparam logic signed [1:0] CHAR_POS  = 2'sb01;
   localparam logic signed [1:0] CHAR_NEG  = 2'sb11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_MUL,
      ST_EMIT,
      ST_EXH
   } state_type;

   // 4 == 1 mod 3, so base-4 digit sums keep the residue
   function automatic logic signed [1:0] mod3_char(input logic [LIMIT_BITS-1:0] v);
      logic [31:0] w;
      logic [5:0]  s1;
      logic [3:0]  s2;
      logic [2:0]  s3;
      logic [1:0]  r;
      logic signed [1:0] c;
      w  = 32'(v);
      s1 = '0;
      for (int i = 0; i < 16; i++) begin
         s1 = s1 + 6'(w[2*i +: 2]);
      end
      s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
      // s2 is at most 9, so s3 is at most 4
      s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
      if (s3 >= 3'd3) begin
         r = 2'(s3 - 3'd3);
      end else begin
         r = s3[1:0];
      end
      case (r)
         2'd1:    c = CHAR_POS;
         2'd2:    c = CHAR_NEG;
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/prime_power_sieve_mod3_character_unit.sv -----
// Prime-power sieve: each advance beat scans the mark RAM upward from the cursor
// for the next unmarked p up to csr_upper_limit, writes a mark at every multiple
// 2p, 3p, ... up to the limit, then returns p, p^2, ... with the mod-3 character
// of each power, rsp_last on the final one, or a single exhausted beat when no
// prime is left. The marking pass is bounded by the single write port of the 1-bit
// mark RAM (one mark per cycle) and the scan by its one-per-cycle reads; an idle
// beat (advance 0) leaves the sieve idle with no response. After reset and after
// every csr write the RAM is cleared from address 0 up to upper_limit (all 2^20
// entries after reset), during which req_ready stays low; a csr write restarts
// the sieve from 2 over the new range.
module prime_power_sieve_mod3_character_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_advance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ppsm_pkg::LIMIT_BITS-1:0]      rsp_power_value,
   output logic [ppsm_pkg::LIMIT_BITS-1:0]      rsp_base_prime,
   output logic signed [1:0]                    rsp_residue_character,
   output logic                                 rsp_exhausted,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppsm_pkg::LIMIT_BITS-1:0]      csr_upper_limit
);

   ppsm_pkg::state_type state_ff, state_in;

   logic [ppsm_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [ppsm_pkg::CUR_BITS-1:0]   cursor_ff, cursor_in;
   logic [ppsm_pkg::LIMIT_BITS-1:0] clr_ff, clr_in;
   logic [ppsm_pkg::CUR_BITS-1:0]   rd_ff, rd_in;
   logic [ppsm_pkg::CUR_BITS-1:0]   chk_ff, chk_in;
   logic                            chk_vld_ff, chk_vld_in;
   logic [ppsm_pkg::LIMIT_BITS-1:0] p_ff, p_in;
   logic [ppsm_pkg::CUR_BITS-1:0]   m_ff, m_in;
   logic [ppsm_pkg::LIMIT_BITS-1:0] pk_ff, pk_in;
   logic [ppsm_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [1:0]               chr_ff, chr_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ppsm_pkg::LIMIT_BITS-1:0] rsp_power_ff, rsp_power_in;
   logic [ppsm_pkg::LIMIT_BITS-1:0] rsp_base_ff, rsp_base_in;
   logic signed [1:0]               rsp_char_ff, rsp_char_in;
   logic                            rsp_exh_ff, rsp_exh_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            ram_we;
   logic [ppsm_pkg::LIMIT_BITS-1:0] ram_waddr;
   logic [0:0]                      ram_wdata;
   logic [0:0]                      ram_rdata;

   logic                            req_fire;
   logic                            csr_fire;
   logic                            rsp_free;
   logic [ppsm_pkg::CUR_BITS-1:0]   limit_ext;
   logic [ppsm_pkg::CUR_BITS-1:0]   limit_next;
   logic                            chk_past;
   logic                            mark_done;
   logic                            last_pow;

   ppsm_mark_ram #(
      .ADDR_BITS (ppsm_pkg::LIMIT_BITS),
      .DATA_BITS (1)
   ) u_mark_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_ff[ppsm_pkg::LIMIT_BITS-1:0]),
      .rdata (ram_rdata)
   );

   assign req_ready  = (state_ff == ppsm_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_valid && req_ready;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign limit_ext  = {1'b0, limit_ff};
   assign limit_next = limit_ext + ppsm_pkg::CUR_BITS'(1);
   assign chk_past   = chk_ff > limit_ext;
   assign mark_done  = m_ff > limit_ext;
   assign last_pow   = prod_ff > ppsm_pkg::PROD_BITS'(limit_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_fire) begin
         state_in = ppsm_pkg::ST_CLEAR;
      end else begin
         unique case (state_ff)
            ppsm_pkg::ST_CLEAR: begin
               if (clr_ff == limit_ff) state_in = ppsm_pkg::ST_IDLE;
            end
            ppsm_pkg::ST_IDLE: begin
               if (req_fire && req_advance) state_in = ppsm_pkg::ST_SCAN;
            end
            ppsm_pkg::ST_SCAN: begin
               if (chk_vld_ff) begin
                  priority if (chk_past) state_in = ppsm_pkg::ST_EXH;
                  else if (!ram_rdata[0]) state_in = ppsm_pkg::ST_MARK;
                  else state_in = ppsm_pkg::ST_SCAN;
               end
            end
            ppsm_pkg::ST_MARK: begin
               if (mark_done) state_in = ppsm_pkg::ST_MUL;
            end
            ppsm_pkg::ST_MUL: begin
               state_in = ppsm_pkg::ST_EMIT;
            end
            ppsm_pkg::ST_EMIT: begin
               if (rsp_free) state_in = last_pow ? ppsm_pkg::ST_IDLE : ppsm_pkg::ST_MUL;
            end
            ppsm_pkg::ST_EXH: begin
               if (rsp_free) state_in = ppsm_pkg::ST_IDLE;
            end
            default: state_in = ppsm_pkg::ST_IDLE;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      limit_in     = limit_ff;
      cursor_in    = cursor_ff;
      clr_in       = clr_ff;
      rd_in        = rd_ff;
      chk_in       = chk_ff;
      chk_vld_in   = chk_vld_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      pk_in        = pk_ff;
      prod_in      = prod_ff;
      chr_in       = chr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_power_in = rsp_power_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_exh_in   = rsp_exh_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = 1'b0;

      unique case (state_ff)
         ppsm_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = clr_ff + ppsm_pkg::LIMIT_BITS'(1);
         end
         ppsm_pkg::ST_IDLE: begin
            rd_in      = cursor_ff;
            chk_vld_in = 1'b0;
         end
         ppsm_pkg::ST_SCAN: begin
            // read data returns in the cycle after its address, alongside chk_ff
            rd_in      = rd_ff + ppsm_pkg::CUR_BITS'(1);
            chk_in     = rd_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               priority if (chk_past) begin
                  if (cursor_ff < limit_next) cursor_in = limit_next;
               end else if (!ram_rdata[0]) begin
                  p_in      = chk_ff[ppsm_pkg::LIMIT_BITS-1:0];
                  pk_in     = chk_ff[ppsm_pkg::LIMIT_BITS-1:0];
                  m_in      = chk_ff + chk_ff;
                  cursor_in = chk_ff + ppsm_pkg::CUR_BITS'(1);
               end else begin
                  // marked number, keep scanning
                  cursor_in = cursor_ff;
               end
            end
         end
         ppsm_pkg::ST_MARK: begin
            if (!mark_done) begin
               ram_we    = 1'b1;
               ram_waddr = m_ff[ppsm_pkg::LIMIT_BITS-1:0];
               ram_wdata = 1'b1;
               m_in      = m_ff + ppsm_pkg::CUR_BITS'(p_ff);
            end
         end
         ppsm_pkg::ST_MUL: begin
            prod_in = ppsm_pkg::PROD_BITS'(pk_ff) * ppsm_pkg::PROD_BITS'(p_ff);
            chr_in  = ppsm_pkg::mod3_char(pk_ff);
         end
         ppsm_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = pk_ff;
               rsp_base_in  = p_ff;
               rsp_char_in  = chr_ff;
               rsp_exh_in   = 1'b0;
               rsp_last_in  = last_pow;
               // not last means the product is within the limit
               pk_in        = prod_ff[ppsm_pkg::LIMIT_BITS-1:0];
            end
         end
         ppsm_pkg::ST_EXH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = '0;
               rsp_base_in  = '0;
               rsp_char_in  = ppsm_pkg::CHAR_ZERO;
               rsp_exh_in   = 1'b1;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            chk_vld_in = 1'b0;
         end
      endcase

      if (csr_fire) begin
         limit_in  = csr_upper_limit;
         cursor_in = ppsm_pkg::CURSOR_START;
         clr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppsm_pkg::ST_CLEAR;
         limit_ff     <= ppsm_pkg::LIMIT_RESET;
         cursor_ff    <= ppsm_pkg::CURSOR_START;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         cursor_ff    <= cursor_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      chk_ff       <= chk_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      pk_ff        <= pk_in;
      prod_ff      <= prod_in;
      chr_ff       <= chr_in;
      rsp_power_ff <= rsp_power_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_exh_ff   <= rsp_exh_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_power_value       = rsp_power_ff;
   assign rsp_base_prime        = rsp_base_ff;
   assign rsp_residue_character = rsp_char_ff;
   assign rsp_exhausted         = rsp_exh_ff;
   assign rsp_last              = rsp_last_ff;

   a_ram_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_waddr} <= limit_ext))
      else $error("mark ram written above the limit");

   a_exhausted_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exh_ff) |-> (rsp_last_ff && rsp_power_ff == '0 && rsp_base_ff == '0))
      else $error("exhausted beat carries a power or is not last");

   a_power_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_exh_ff) |->
         (rsp_base_ff >= ppsm_pkg::LIMIT_BITS'(2) && rsp_power_ff >= rsp_base_ff))
      else $error("power beat below its base prime");

   a_cursor_floor: assert property (@(posedge clock) disable iff (reset)
      cursor_ff >= ppsm_pkg::CURSOR_START)
      else $error("scan cursor fell below two");

endmodule

// ----- rtl/ppsm_mark_ram.sv -----
module ppsm_mark_ram #(
   parameter int ADDR_BITS = 20,
   parameter int DATA_BITS = 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
